// File: rtl/imts_pkg.sv
`default_nettype none
package imts_pkg;

	// Line phase, one-hot
	typedef enum logic [6:0] {
		PH_START   = 7'b0000001,
		PH_SECTION = 7'b0000010,
		PH_KEY     = 7'b0000100,
		PH_VALUE   = 7'b0001000,
		PH_IGNORE  = 7'b0010000,
		PH_MARK1   = 7'b0100000,
		PH_MARK2   = 7'b1000000
	} phase_t;

	// Result status codes
	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_NO_DECL = 2'd1;
	localparam logic [1:0] ST_TWICE   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	// Theater codes
	localparam logic [1:0] TH_TEMPERATE = 2'd0;
	localparam logic [1:0] TH_DESERT    = 2'd1;
	localparam logic [1:0] TH_WINTER    = 2'd2;

	// Special bytes
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_RBRK = 8'h5D;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] BOM_0   = 8'hEF;
	localparam logic [7:0] BOM_1   = 8'hBB;
	localparam logic [7:0] BOM_2   = 8'hBF;

	// Keyword lengths
	localparam logic [3:0] LEN_MAP       = 4'd3;
	localparam logic [3:0] LEN_THEATER   = 4'd7;
	localparam logic [3:0] LEN_TEMPERATE = 4'd9;
	localparam logic [3:0] LEN_SIX       = 4'd6;
	localparam logic [3:0] KIDX_MAX      = 4'd15;

	// Keywords, zero padded to a power-of-two depth; reads are guarded by length
	localparam logic [7:0] WORD_MAP [4] = '{"M", "A", "P", 8'h00};
	localparam logic [7:0] WORD_THEATER [8] = '{"T", "H", "E", "A", "T", "E", "R", 8'h00};
	localparam logic [7:0] WORD_TEMPERATE [16] = '{"T", "E", "M", "P", "E", "R", "A", "T",
		"E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] WORD_DESERT [8] = '{"D", "E", "S", "E", "R", "T", 8'h00, 8'h00};
	localparam logic [7:0] WORD_WINTER [8] = '{"W", "I", "N", "T", "E", "R", 8'h00, 8'h00};

	typedef struct packed {
		logic [1:0] file_pos;
		logic       in_map;
		phase_t     phase;
		logic [3:0] kidx;
		logic [2:0] alive;      // temperate, desert, winter matchers
		logic       pending;
		logic [1:0] decl_cnt;
		logic [1:0] first_th;
		logic       first_known;
	} scan_state_t;

	localparam scan_state_t RESET_STATE = '{
		file_pos:    2'd0,
		in_map:      1'b0,
		phase:       PH_START,
		kidx:        4'd0,
		alive:       3'b111,
		pending:     1'b0,
		decl_cnt:    2'd0,
		first_th:    2'd0,
		first_known: 1'b0
	};

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       final_byte;
	} step_t;

	typedef struct packed {
		logic [1:0] scan_status;
		logic [1:0] theater_code;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/imts_if.sv
`default_nettype none
interface imts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface imts_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] scan_status;
	logic [1:0] theater_code;

	modport source (output valid, output scan_status, output theater_code, input ready);
	modport sink (input valid, input scan_status, input theater_code, output ready);
endinterface
`default_nettype wire

// File: rtl/imts_scan_core.sv
`default_nettype none
module imts_scan_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire imts_pkg::step_t step,
	output imts_pkg::result_t    result
);

	imts_pkg::scan_state_t state_q;
	imts_pkg::scan_state_t after_byte;
	imts_pkg::scan_state_t after_line;

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0C || c == 8'h0B;
	endfunction

	function automatic logic [7:0] to_upper(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic imts_pkg::scan_state_t clear_line(imts_pkg::scan_state_t s_in);
		imts_pkg::scan_state_t s;
		s = s_in;
		s.phase   = imts_pkg::PH_START;
		s.kidx    = 4'd0;
		s.alive   = 3'b111;
		s.pending = 1'b0;
		return s;
	endfunction

	// Commit what the line decided
	function automatic imts_pkg::scan_state_t finish_line(imts_pkg::scan_state_t s_in);
		imts_pkg::scan_state_t s;
		s = s_in;
		if (s.phase == imts_pkg::PH_SECTION) begin
			s.in_map = (s.kidx == imts_pkg::LEN_MAP + 4'd1);
		end else if (s.phase == imts_pkg::PH_VALUE) begin
			if (s.alive[0] && s.kidx == imts_pkg::LEN_TEMPERATE) begin
				s.first_known = 1'b1;
				s.first_th    = imts_pkg::TH_TEMPERATE;
			end else if (s.alive[1] && s.kidx == imts_pkg::LEN_SIX) begin
				s.first_known = 1'b1;
				s.first_th    = imts_pkg::TH_DESERT;
			end else if (s.alive[2] && s.kidx == imts_pkg::LEN_SIX) begin
				s.first_known = 1'b1;
				s.first_th    = imts_pkg::TH_WINTER;
			end
		end
		s.phase = imts_pkg::PH_IGNORE;
		return s;
	endfunction

	function automatic imts_pkg::scan_state_t key_char(imts_pkg::scan_state_t s_in,
		logic [7:0] c);
		imts_pkg::scan_state_t s;
		s = s_in;
		if (is_space(c)) begin
			if (s.kidx == imts_pkg::LEN_THEATER) s.pending = 1'b1;
			else s.phase = imts_pkg::PH_IGNORE;
		end else if (c == imts_pkg::CH_EQ) begin
			if (s.kidx != imts_pkg::LEN_THEATER) begin
				s.phase = imts_pkg::PH_IGNORE;
			end else begin
				if (s.decl_cnt != 2'd2) s.decl_cnt = s.decl_cnt + 2'd1;
				if (s.decl_cnt == 2'd1) begin
					s.phase   = imts_pkg::PH_VALUE;
					s.kidx    = 4'd0;
					s.alive   = 3'b111;
					s.pending = 1'b0;
				end else begin
					s.phase = imts_pkg::PH_IGNORE;
				end
			end
		end else if (!s.pending && s.kidx < imts_pkg::LEN_THEATER
			&& imts_pkg::WORD_THEATER[s.kidx[2:0]] == to_upper(c)) begin
			s.kidx = s.kidx + 4'd1;
		end else begin
			s.phase = imts_pkg::PH_IGNORE;
		end
		return s;
	endfunction

	function automatic imts_pkg::scan_state_t value_char(imts_pkg::scan_state_t s_in,
		logic [7:0] c);
		imts_pkg::scan_state_t s;
		logic [7:0] u;
		s = s_in;
		u = to_upper(c);
		if (is_space(c)) begin
			if (s.kidx != 4'd0) s.pending = 1'b1;
		end else begin
			if (s.pending) begin
				s.alive = 3'b000;
			end else begin
				if (!(s.kidx < imts_pkg::LEN_TEMPERATE
					&& imts_pkg::WORD_TEMPERATE[s.kidx] == u)) s.alive[0] = 1'b0;
				if (!(s.kidx < imts_pkg::LEN_SIX
					&& imts_pkg::WORD_DESERT[s.kidx[2:0]] == u)) s.alive[1] = 1'b0;
				if (!(s.kidx < imts_pkg::LEN_SIX
					&& imts_pkg::WORD_WINTER[s.kidx[2:0]] == u)) s.alive[2] = 1'b0;
			end
			if (s.kidx != imts_pkg::KIDX_MAX) s.kidx = s.kidx + 4'd1;
		end
		return s;
	endfunction

	function automatic imts_pkg::scan_state_t section_char(imts_pkg::scan_state_t s_in,
		logic [7:0] c);
		imts_pkg::scan_state_t s;
		s = s_in;
		if (is_space(c)) begin
			if (s.kidx == 4'd1 || s.kidx == 4'd2) s.phase = imts_pkg::PH_IGNORE;
		end else if (c == imts_pkg::CH_RBRK) begin
			if (s.kidx == imts_pkg::LEN_MAP) s.kidx = imts_pkg::LEN_MAP + 4'd1;
			else s.phase = imts_pkg::PH_IGNORE;
		end else if (s.kidx < imts_pkg::LEN_MAP
			&& imts_pkg::WORD_MAP[s.kidx[1:0]] == to_upper(c)) begin
			s.kidx = s.kidx + 4'd1;
		end else begin
			s.phase = imts_pkg::PH_IGNORE;
		end
		return s;
	endfunction

	function automatic imts_pkg::scan_state_t start_char(imts_pkg::scan_state_t s_in,
		logic [7:0] c);
		imts_pkg::scan_state_t s;
		s = s_in;
		if (!is_space(c)) begin
			if (c == imts_pkg::CH_LBRK) begin
				s.in_map = 1'b0;
				s.phase  = imts_pkg::PH_SECTION;
				s.kidx   = 4'd0;
			end else if (s.in_map) begin
				s.phase   = imts_pkg::PH_KEY;
				s.kidx    = 4'd0;
				s.pending = 1'b0;
				s       = key_char(s, c);
			end else begin
				s.phase = imts_pkg::PH_IGNORE;
			end
		end
		return s;
	endfunction

	function automatic imts_pkg::scan_state_t byte_step(imts_pkg::scan_state_t s_in,
		logic [7:0] c);
		imts_pkg::scan_state_t s;
		s = s_in;
		if (c == imts_pkg::CH_LF) begin
			s = clear_line(finish_line(s));
		end else if (s.phase == imts_pkg::PH_MARK1) begin
			s.phase = (c == imts_pkg::BOM_1) ? imts_pkg::PH_MARK2 : imts_pkg::PH_IGNORE;
		end else if (s.phase == imts_pkg::PH_MARK2) begin
			s.phase = (c == imts_pkg::BOM_2) ? imts_pkg::PH_START : imts_pkg::PH_IGNORE;
		end else if (s.file_pos == 2'd0 && c == imts_pkg::BOM_0) begin
			s.phase = imts_pkg::PH_MARK1;
		end else if (c == imts_pkg::CH_SEMI || c == imts_pkg::CH_HASH) begin
			s = finish_line(s);
		end else begin
			unique case (s.phase)
				imts_pkg::PH_START:   s = start_char(s, c);
				imts_pkg::PH_SECTION: s = section_char(s, c);
				imts_pkg::PH_KEY:     s = key_char(s, c);
				imts_pkg::PH_VALUE:   s = value_char(s, c);
				default: ;
			endcase
		end
		if (s.file_pos != 2'd3) s.file_pos = s.file_pos + 2'd1;
		return s;
	endfunction

	always_comb begin
		after_byte = byte_step(state_q, step.data_byte);
		after_line = finish_line(after_byte);
	end

	always_comb begin
		result.theater_code = imts_pkg::TH_TEMPERATE;
		if (after_line.decl_cnt == 2'd0) begin
			result.scan_status = imts_pkg::ST_NO_DECL;
		end else if (after_line.decl_cnt == 2'd2) begin
			result.scan_status = imts_pkg::ST_TWICE;
		end else if (after_line.first_known) begin
			result.scan_status  = imts_pkg::ST_FOUND;
			result.theater_code = after_line.first_th;
		end else begin
			result.scan_status = imts_pkg::ST_UNKNOWN;
		end
	end

	// Return to the reset state after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imts_pkg::RESET_STATE;
		end else if (step.valid) begin
			state_q <= step.final_byte ? imts_pkg::RESET_STATE : after_byte;
		end
	end

endmodule
`default_nettype wire

// File: rtl/ini_map_theater_scanner.sv
`default_nettype none
// Channel   Role  Payload                              Request
// stream    sink  data_byte[7:0], final_byte           one file byte
// report    src   scan_status[1:0], theater_code[1:0]  one result per file
//
// One byte is taken every cycle while stream.ready is high; the scanner state advances on the byte itself.
// The report for a file appears the cycle after its final byte is taken when the
// report register is empty or draining; otherwise it waits in the spare register.
// stream.ready drops only while the spare register holds a report (two reports wait).
// Reset clears the scanner to the start of a file and empties both report registers.
module ini_map_theater_scanner (
	input wire logic    clk,
	input wire logic    arst_n,
	imts_in_if.sink     stream,
	imts_out_if.source  report
);

	imts_pkg::step_t   step;
	imts_pkg::result_t core_result;
	imts_pkg::result_t result_q;
	imts_pkg::result_t spare_q;
	logic              report_valid_q;
	logic              spare_valid_q;
	logic              accept;
	logic              load;
	logic              advance;

	// Take a new request while the spare register is free; the ready path never
	// depends on report.ready
	assign stream.ready = !spare_valid_q;
	assign accept       = stream.valid && stream.ready;
	assign load         = accept && stream.final_byte;
	// Report register is empty or drained this cycle
	assign advance      = !report_valid_q || report.ready;

	assign step.valid      = accept;
	assign step.data_byte  = stream.data_byte;
	assign step.final_byte = stream.final_byte;

	imts_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (core_result)
	);

	// Hold the report until taken; refill from the spare first, then from a final byte.
	// Park a final byte's report in the spare while the report register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
			spare_valid_q  <= 1'b0;
		end else if (advance) begin
			report_valid_q <= spare_valid_q || load;
			spare_valid_q  <= 1'b0;
		end else if (load) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (spare_valid_q || load)) begin
			result_q <= spare_valid_q ? spare_q : core_result;
		end
		if (!advance && load) begin
			spare_q <= core_result;
		end
	end

	assign report.valid        = report_valid_q;
	assign report.scan_status  = result_q.scan_status;
	assign report.theater_code = result_q.theater_code;

`ifndef SYNTH
	a_report_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(report_valid_q) |-> $past(load))
		else $error("report raised without a final byte");

	a_spare_behind_report: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> report_valid_q)
		else $error("spare report held with the report register empty");

	a_code_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid_q && result_q.scan_status != imts_pkg::ST_FOUND
		|-> result_q.theater_code == imts_pkg::TH_TEMPERATE)
		else $error("theater code set on a failed scan");
`endif

endmodule
`default_nettype wire

// File: dv/ini_map_theater_scanner_test.sv
`default_nettype none
module ini_map_theater_scanner_test;
	import imts_pkg::*;

	// Cycles with no request taken on either channel before the run is abandoned
	localparam int IDLE_LIMIT   = 1000;
	// Byte budgets for the random parts
	localparam int RANDOM_BYTES = 1280;
	localparam int NOISE_BYTES  = 350;
	localparam int MIN_FILES    = 20;

	// Blank bytes that the scanner trims
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_VT    = 8'h0B;

	// Keywords, right justified, first letter highest
	localparam logic [71:0] TXT_MAP       = "MAP";
	localparam logic [71:0] TXT_THEATER   = "THEATER";
	localparam logic [71:0] TXT_TEMPERATE = "TEMPERATE";
	localparam logic [71:0] TXT_DESERT    = "DESERT";
	localparam logic [71:0] TXT_WINTER    = "WINTER";

	logic clk;
	logic arst_n;

	imts_in_if  stream_if ();
	imts_out_if report_if ();

	ini_map_theater_scanner u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.report (report_if)
	);

	// Scanner state as predicted, one byte at a time
	phase_t     sc_phase;
	logic [1:0] sc_pos;
	logic       sc_in_map;
	logic [3:0] sc_idx;
	logic [2:0] sc_alive;        // bit 0 temperate, bit 1 desert, bit 2 winter
	logic       sc_pending;
	logic [1:0] sc_decls;
	logic [1:0] sc_first;
	logic       sc_first_known;

	// Reports owed by the block, oldest first
	result_t    theater_reports[$];
	// Bytes of the file being assembled for sending
	logic [7:0] file_bytes[$];

	int failures;
	int bytes_taken;
	int burst_left;
	int idle_cycles;
	int stall_left;
	int stall_mode;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_FF || c == CH_VT;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// Letter i of a keyword of len letters; the caller keeps i below len
	function automatic logic [7:0] word_char(input logic [71:0] word, input int len, input int i);
		return word[8 * (len - 1 - i) +: 8];
	endfunction

	function automatic void open_line();
		sc_phase   = PH_START;
		sc_idx     = 4'd0;
		sc_alive   = 3'b111;
		sc_pending = 1'b0;
	endfunction

	function automatic void open_file();
		sc_pos         = 2'd0;
		sc_in_map      = 1'b0;
		sc_decls       = 2'd0;
		sc_first       = TH_TEMPERATE;
		sc_first_known = 1'b0;
		open_line();
	endfunction

	// Commit what the line decided, then ignore the rest of it
	function automatic void close_line();
		if (sc_phase == PH_SECTION) begin
			sc_in_map = (sc_idx == 4'd4);
		end else if (sc_phase == PH_VALUE) begin
			if (sc_alive[0] && sc_idx == 4'd9) begin
				sc_first_known = 1'b1;
				sc_first       = TH_TEMPERATE;
			end else if (sc_alive[1] && sc_idx == 4'd6) begin
				sc_first_known = 1'b1;
				sc_first       = TH_DESERT;
			end else if (sc_alive[2] && sc_idx == 4'd6) begin
				sc_first_known = 1'b1;
				sc_first       = TH_WINTER;
			end
		end
		sc_phase = PH_IGNORE;
	endfunction

	function automatic void take_value_char(input logic [7:0] c);
		logic [7:0] u;
		u = upcase(c);
		if (is_blank(c)) begin
			// trailing blanks are harmless, inner ones kill every match
			if (sc_idx != 4'd0)
				sc_pending = 1'b1;
		end else begin
			if (sc_pending) begin
				sc_alive = 3'b000;
			end else begin
				if (!(sc_idx < 9 && word_char(TXT_TEMPERATE, 9, sc_idx) == u))
					sc_alive[0] = 1'b0;
				if (!(sc_idx < 6 && word_char(TXT_DESERT, 6, sc_idx) == u))
					sc_alive[1] = 1'b0;
				if (!(sc_idx < 6 && word_char(TXT_WINTER, 6, sc_idx) == u))
					sc_alive[2] = 1'b0;
			end
			if (sc_idx < 4'd15)
				sc_idx++;
		end
	endfunction

	function automatic void take_key_char(input logic [7:0] c);
		if (is_blank(c)) begin
			if (sc_idx == 4'd7)
				sc_pending = 1'b1;
			else
				sc_phase = PH_IGNORE;
		end else if (c == CH_EQ) begin
			if (sc_idx != 4'd7) begin
				sc_phase = PH_IGNORE;
			end else begin
				if (sc_decls < 2'd2)
					sc_decls++;
				// only the first declaration has its value scanned
				if (sc_decls == 2'd1) begin
					sc_phase   = PH_VALUE;
					sc_idx     = 4'd0;
					sc_alive   = 3'b111;
					sc_pending = 1'b0;
				end else begin
					sc_phase = PH_IGNORE;
				end
			end
		end else if (!sc_pending && sc_idx < 7
				&& word_char(TXT_THEATER, 7, sc_idx) == upcase(c)) begin
			sc_idx++;
		end else begin
			sc_phase = PH_IGNORE;
		end
	endfunction

	function automatic void take_section_char(input logic [7:0] c);
		if (is_blank(c)) begin
			if (sc_idx == 4'd1 || sc_idx == 4'd2)
				sc_phase = PH_IGNORE;
		end else if (c == CH_RBRK) begin
			if (sc_idx == 4'd3)
				sc_idx = 4'd4;
			else
				sc_phase = PH_IGNORE;
		end else if (sc_idx < 3 && word_char(TXT_MAP, 3, sc_idx) == upcase(c)) begin
			sc_idx++;
		end else begin
			sc_phase = PH_IGNORE;
		end
	endfunction

	function automatic void take_line_start(input logic [7:0] c);
		if (is_blank(c)) begin
		end else if (c == CH_LBRK) begin
			sc_in_map = 1'b0;
			sc_phase  = PH_SECTION;
			sc_idx    = 4'd0;
		end else if (sc_in_map) begin
			sc_phase   = PH_KEY;
			sc_idx     = 4'd0;
			sc_pending = 1'b0;
			take_key_char(c);
		end else begin
			sc_phase = PH_IGNORE;
		end
	endfunction

	// Advance the predicted scanner by one byte; return 1 with the report on a final byte
	function automatic logic scan_byte(input logic [7:0] c, input logic last,
			output result_t rpt);
		rpt = '0;
		if (c == CH_LF) begin
			close_line();
			open_line();
		end else if (sc_phase == PH_MARK1) begin
			sc_phase = (c == BOM_1) ? PH_MARK2 : PH_IGNORE;
		end else if (sc_phase == PH_MARK2) begin
			sc_phase = (c == BOM_2) ? PH_START : PH_IGNORE;
		end else if (sc_pos == 2'd0 && c == BOM_0) begin
			sc_phase = PH_MARK1;
		end else if (c == CH_SEMI || c == CH_HASH) begin
			close_line();
		end else begin
			case (sc_phase)
				PH_START:   take_line_start(c);
				PH_SECTION: take_section_char(c);
				PH_KEY:     take_key_char(c);
				PH_VALUE:   take_value_char(c);
				default: ;
			endcase
		end
		if (sc_pos < 2'd3)
			sc_pos++;
		if (!last)
			return 1'b0;
		close_line();
		if (sc_decls == 2'd0) begin
			rpt.scan_status = ST_NO_DECL;
		end else if (sc_decls >= 2'd2) begin
			rpt.scan_status = ST_TWICE;
		end else if (sc_first_known) begin
			rpt.scan_status  = ST_FOUND;
			rpt.theater_code = sc_first;
		end else begin
			rpt.scan_status = ST_UNKNOWN;
		end
		open_file();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// File assembly
	// ------------------------------------------------------------------

	// Append one byte to the file being assembled
	function automatic void append_byte(input logic [7:0] b);
		file_bytes.insert(file_bytes.size(), b);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endfunction

	// Append with letters in random case
	function automatic void add_word(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1))
				c = c ^ 8'h20;
			append_byte(c);
		end
	endfunction

	// Append zero to two blank bytes of random kinds
	function automatic void add_pad();
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 4))
				0: append_byte(CH_SPACE);
				1: append_byte(CH_TAB);
				2: append_byte(CH_CR);
				3: append_byte(CH_FF);
				default: append_byte(CH_VT);
			endcase
		end
	endfunction

	// Mostly well-formed files with random content, some broken lines and noise
	function automatic void build_random_file();
		int lines;
		int kind;
		case ($urandom_range(0, 11))
			0: begin
				append_byte(BOM_0);
				append_byte(BOM_1);
				append_byte(BOM_2);
			end
			1: append_byte(BOM_0);
			2: begin
				append_byte(BOM_0);
				append_byte(BOM_1);
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0)
			add_word("[map]\n");
		lines = $urandom_range(1, 5);
		for (int n = 0; n < lines; n++) begin
			kind = $urandom_range(0, 11);
			if (kind < 2) begin
				// section header, sometimes malformed
				add_pad();
				add_text("[");
				add_pad();
				case ($urandom_range(0, 5))
					0, 1: add_word("map");
					2: add_word("ma p");
					3: add_word("maps");
					4: add_word("ma");
					default: add_word("rules");
				endcase
				add_pad();
				if ($urandom_range(0, 7) != 0)
					add_text("]");
				add_pad();
			end else if (kind < 9) begin
				// key = value
				add_pad();
				case ($urandom_range(0, 9))
					0: add_word("theate");
					1: add_word("theaterx");
					2: add_word("thea ter");
					3: add_word("name");
					default: add_word("theater");
				endcase
				add_pad();
				if ($urandom_range(0, 9) != 0)
					add_text("=");
				add_pad();
				case ($urandom_range(0, 11))
					0, 1: add_word("temperate");
					2, 3: add_word("desert");
					4, 5: add_word("winter");
					6: ;
					7: add_word("des ert");
					8: add_word("winterx");
					9: add_word("temperatetemperate");
					10: add_word("tempera");
					default: begin
						repeat ($urandom_range(1, 10))
							append_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61)
								+ 8'($urandom_range(0, 25)));
					end
				endcase
				add_pad();
			end else if (kind == 9) begin
				repeat ($urandom_range(1, 8))
					append_byte(8'($urandom_range(0, 255)));
			end else begin
				add_pad();
			end
			if ($urandom_range(0, 3) == 0) begin
				add_text($urandom_range(0, 1) ? ";" : "#");
				add_word("theater=desert");
			end
			if (n < lines - 1 || $urandom_range(0, 1))
				add_text("\n");
		end
		if (file_bytes.size() == 0)
			append_byte(8'($urandom_range(0, 255)));
	endfunction

	// ------------------------------------------------------------------
	// Stream driver
	// ------------------------------------------------------------------

	// Offer one byte at the falling edge, hold it until the request is taken.
	// Insert a random gap before each burst.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		result_t rpt;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				stream_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		stream_if.valid      <= 1'b1;
		stream_if.data_byte  <= b;
		stream_if.final_byte <= last;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		if (scan_byte(b, last, rpt))
			theater_reports.insert(theater_reports.size(), rpt);
		bytes_taken++;
		@(negedge clk);
	endtask

	// Send the assembled file, marking its last byte, then clear it
	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_bytes.delete();
	endtask

	// Drop valid and hold until every owed report has been taken
	task automatic wait_for_reports();
		stream_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (theater_reports.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_each_theater();
		add_text("[Map]\nTheater=temperate");
		send_file();
		add_text("[ map ]\n theater = DESERT \n");
		send_file();
		add_text("[MAP]\nTHEATER=Winter;x\n");
		send_file();
		// a later section leaves the map before the key
		add_text("[map]\n[rules]\ntheater=desert");
		send_file();
	endtask

	task automatic test_byte_order_mark();
		// full mark is dropped
		append_byte(BOM_0);
		append_byte(BOM_1);
		append_byte(BOM_2);
		add_text("[map]\ntheater=desert");
		send_file();
		// lone EF spoils the first line
		append_byte(BOM_0);
		add_text("[map]\ntheater=desert");
		send_file();
		// EF BB spoils only its own line
		append_byte(BOM_0);
		append_byte(BOM_1);
		add_text("\n[map]\ntheater=winter#c");
		send_file();
	endtask

	task automatic test_declaration_counts();
		add_text("x");
		send_file();
		add_text("[map]\ntheater=desert\ntheater=winter\n");
		send_file();
		add_text("[map]\ntheater=\ntheater=a\ntheater=b");
		send_file();
	endtask

	task automatic test_odd_values();
		// empty value, inner blank, long token, blank inside the key
		add_text("[map]\ntheater=");
		send_file();
		add_text("[map]\ntheater = win ter");
		send_file();
		add_text("[map]\ntheater=temperatetemperate");
		send_file();
		add_text("[map]\nthe ater=desert");
		send_file();
	endtask

	task automatic test_byte_extremes();
		append_byte(8'h00);
		send_file();
		append_byte(8'hFF);
		send_file();
		append_byte(CH_LF);
		send_file();
		append_byte(BOM_0);
		send_file();
	endtask

	task automatic test_random_files();
		int files;
		int first_byte;
		files = 0;
		first_byte = bytes_taken;
		while (bytes_taken - first_byte < RANDOM_BYTES || files < MIN_FILES) begin
			// now and then let the report side catch up completely
			if (files % 9 == 0)
				wait_for_reports();
			build_random_file();
			send_file();
			files++;
		end
	endtask

	task automatic test_random_noise();
		int first_byte;
		first_byte = bytes_taken;
		while (bytes_taken - first_byte < NOISE_BYTES) begin
			repeat ($urandom_range(1, 30))
				append_byte(8'($urandom_range(0, 255)));
			send_file();
		end
	endtask

	// ------------------------------------------------------------------
	// Report side
	// ------------------------------------------------------------------

	// Report ready: change the stall mode every so often, from never
	// stalling to mostly stalled.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 120);
		end
		stall_left--;
		case (stall_mode)
			0: report_if.ready <= 1'b1;
			1: report_if.ready <= ($urandom_range(0, 3) != 0);
			2: report_if.ready <= 1'($urandom_range(0, 1));
			default: report_if.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Check each taken report against the oldest one owed
	always @(posedge clk) begin : check_report
		result_t want;
		if (arst_n && report_if.valid && report_if.ready) begin
			if (theater_reports.size() == 0) begin
				$error("report with none owed: scan_status %0d theater_code %0d",
					report_if.scan_status, report_if.theater_code);
				failures++;
			end else begin
				want = theater_reports.pop_front();
				if (report_if.scan_status !== want.scan_status) begin
					$error("scan_status expected %0d actual %0d",
						want.scan_status, report_if.scan_status);
					failures++;
				end
				if (report_if.theater_code !== want.theater_code) begin
					$error("theater_code expected %0d actual %0d",
						want.theater_code, report_if.theater_code);
					failures++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no request moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (stream_if.valid && stream_if.ready)
				|| (report_if.valid && report_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ini_map_theater_scanner_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		stream_if.valid      = 1'b0;
		stream_if.data_byte  = 8'h00;
		stream_if.final_byte = 1'b0;
		report_if.ready      = 1'b0;
		failures             = 0;
		bytes_taken          = 0;
		burst_left           = 0;
		idle_cycles          = 0;
		stall_left           = 0;
		stall_mode           = 0;
		open_file();

		// hold reset, then release it at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_each_theater();
		test_byte_order_mark();
		test_declaration_counts();
		test_odd_values();
		test_byte_extremes();
		test_random_files();
		test_random_noise();

		// drain, then idle so that the block can show anything stray
		wait_for_reports();
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("ini_map_theater_scanner_test OK");
		else
			$display("ini_map_theater_scanner_test NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/imts_pkg.sv
rtl/imts_if.sv
rtl/imts_scan_core.sv
rtl/ini_map_theater_scanner.sv
dv/ini_map_theater_scanner_test.sv
